[rtl/wuo_pkg.sv]
// Shared widths, register indexes, opcodes and controller/datapath types.
package wuo_pkg;

  localparam int PHASE_W    = 27;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 12;
  localparam int VC_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;
  localparam int TADDR_W    = 11;
  localparam int VOICE_W    = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH = 2'd0,
    REG_PHASE_INC    = 2'd1,
    REG_DETUNE_INC   = 2'd2,
    REG_VOICE_COUNT  = 2'd3
  } reg_index_t;

  // Input item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Register reset values
  localparam logic [LEN_W-1:0]   LEN_RESET  = 12'd2048;
  localparam logic [PHASE_W-1:0] PINC_RESET = 27'd1230307;
  localparam logic [PHASE_W-1:0] DET_RESET  = 27'd2796;
  localparam logic [VC_W-1:0]    VC_RESET   = 2'd1;

  // Divide by three: floor(m / 3) = (m * 0xAAAB) >> 17 for m below 2^16 + 1
  localparam logic [15:0] DIV3_MUL   = 16'hAAAB;
  localparam int          DIV3_SHIFT = 17;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic               table_write;
    logic               clear;
    logic               phase_step;
    logic               read_a;
    logic               read_b;
    logic               mul;
    logic               interp;
    logic               scale;
    logic               accum;
    logic               emit;
    logic [VOICE_W-1:0] voice;
  } dp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic [VC_W-1:0] active;
    logic            out_blocked;
  } dp_status_t;

endpackage

[rtl/wuo_datapath.sv]
// Datapath: config registers, phase accumulators, wavetable memory, interpolation and mix.
module wuo_datapath #(
  parameter int TABLE_DEPTH = 2048,
  parameter int MAX_VOICES  = 3,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_enable,
  input  logic [wuo_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [wuo_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [wuo_pkg::TADDR_W-1:0]           table_address,
  input  logic signed [wuo_pkg::SAMPLE_W-1:0]   table_value,
  input  wuo_pkg::dp_cmd_t                      cmd,
  output wuo_pkg::dp_status_t                   status,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wuo_pkg::SAMPLE_W-1:0]   sample
);

  localparam int PW      = wuo_pkg::PHASE_W;
  localparam int SW      = wuo_pkg::SAMPLE_W;
  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
  localparam int LW      = (DEPTH_W > wuo_pkg::LEN_W) ? DEPTH_W : wuo_pkg::LEN_W;
  localparam int IDX_W   = PW - FRAC_BITS;
  localparam int SUM_PW  = PW + 3;
  localparam int CMP_W   = (LW + FRAC_BITS > SUM_PW) ? LW + FRAC_BITS : SUM_PW;
  localparam int RD_W    = (IDX_W + 1 > LW) ? IDX_W + 1 : LW;
  localparam int WA_W    = (wuo_pkg::TADDR_W > LW) ? wuo_pkg::TADDR_W : LW;
  localparam int VIW     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int DIFF_W  = SW + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
  localparam int ACC_W   = SW + 3;
  localparam int M3_W    = DIFF_W + 16;

  localparam logic [LW-1:0]          DEPTH_L = LW'(TABLE_DEPTH);
  localparam logic [LW-1:0]          MIN_L   = LW'(2);
  localparam logic [wuo_pkg::VC_W:0] MAXV    = (wuo_pkg::VC_W + 1)'(MAX_VOICES);

  // Configuration registers
  logic [wuo_pkg::LEN_W-1:0] table_length;
  logic [PW-1:0]             phase_increment;
  logic [PW-1:0]             detune_increment;
  logic [wuo_pkg::VC_W-1:0]  voice_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length     <= wuo_pkg::LEN_RESET;
      phase_increment  <= wuo_pkg::PINC_RESET;
      detune_increment <= wuo_pkg::DET_RESET;
      voice_count      <= wuo_pkg::VC_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        wuo_pkg::REG_TABLE_LENGTH: table_length     <= cfg_data[wuo_pkg::LEN_W-1:0];
        wuo_pkg::REG_PHASE_INC:    phase_increment  <= cfg_data[PW-1:0];
        wuo_pkg::REG_DETUNE_INC:   detune_increment <= cfg_data[PW-1:0];
        wuo_pkg::REG_VOICE_COUNT:  voice_count      <= cfg_data[wuo_pkg::VC_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective table length, clamped to [2, TABLE_DEPTH]
  logic [LW-1:0] len_eff;
  always_comb begin
    if (LW'(table_length) < MIN_L) begin
      len_eff = MIN_L;
    end else if (LW'(table_length) > DEPTH_L) begin
      len_eff = DEPTH_L;
    end else begin
      len_eff = LW'(table_length);
    end
  end

  // Active voice count, clamped to the number of accumulators
  logic [wuo_pkg::VC_W-1:0] active_vc;
  assign active_vc = ({1'b0, voice_count} > MAXV) ? MAXV[wuo_pkg::VC_W-1:0] : voice_count;

  // Phase accumulators
  logic [PW-1:0]     phase [MAX_VOICES];
  logic [VIW-1:0]    vi;
  logic [PW-1:0]     cur_phase;
  logic [SUM_PW-1:0] detune_mul;
  logic [SUM_PW-1:0] step_sum;
  logic [CMP_W-1:0]  lenfix;
  logic [CMP_W-1:0]  wrapped;

  assign vi         = cmd.voice[VIW-1:0];
  assign cur_phase  = phase[vi];
  assign detune_mul = SUM_PW'(detune_increment) * SUM_PW'(cmd.voice);
  assign step_sum   = SUM_PW'(cur_phase) + SUM_PW'(phase_increment) + detune_mul;
  assign lenfix     = CMP_W'(len_eff) << FRAC_BITS;
  // One subtraction of the length once the phase reaches or passes it
  assign wrapped    = (CMP_W'(step_sum) >= lenfix) ? CMP_W'(step_sum) - lenfix
                                                   : CMP_W'(step_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        phase[i] <= '0;
      end
    end else if (cmd.phase_step) begin
      phase[vi] <= wrapped[PW-1:0];
    end
  end

  // Read addresses; anything at or past the length reads entry 0
  logic [RD_W-1:0] idx_w;
  logic [RD_W-1:0] idx1_w;
  logic [RD_W-1:0] len_w;
  logic [AW-1:0]   addr_a;
  logic [AW-1:0]   addr_b;
  logic [AW-1:0]   raddr;

  assign idx_w  = RD_W'(cur_phase[PW-1:FRAC_BITS]);
  assign idx1_w = idx_w + RD_W'(1);
  assign len_w  = RD_W'(len_eff);
  assign addr_a = (idx_w < len_w) ? idx_w[AW-1:0] : '0;
  assign addr_b = (idx1_w < len_w) ? idx1_w[AW-1:0] : '0;
  assign raddr  = cmd.read_b ? addr_b : addr_a;

  // Wavetable memory, one write and one registered read port
  logic [SW-1:0]   wave_table [TABLE_DEPTH];
  logic [SW-1:0]   rdata;
  logic [WA_W-1:0] waddr;
  logic            write_ok;

  assign waddr    = WA_W'(table_address);
  assign write_ok = waddr < WA_W'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.table_write && write_ok) begin
      wave_table[waddr[AW-1:0]] <= table_value;
    end
    if (cmd.read_a || cmd.read_b) begin
      rdata <= wave_table[raddr];
    end
  end

  // Interpolation: a + floor((b - a) * frac / 2^FRAC_BITS)
  logic signed [SW-1:0]      entry_a;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [FRAC_BITS:0] frac_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  step_full;
  logic signed [DIFF_W-1:0]  val;
  logic [DIFF_W-1:0]         mag;
  logic                      neg;

  assign diff      = DIFF_W'($signed(rdata)) - DIFF_W'(entry_a);
  assign frac_s    = $signed({1'b0, cur_phase[FRAC_BITS-1:0]});
  assign step_full = prod >>> FRAC_BITS;
  assign val       = DIFF_W'(entry_a) + step_full[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.read_b) begin
      entry_a <= $signed(rdata);
    end
    if (cmd.mul) begin
      prod <= diff * frac_s;
    end
    if (cmd.interp) begin
      neg <= val[DIFF_W-1];
      mag <= val[DIFF_W-1] ? DIFF_W'(-val) : DIFF_W'(val);
    end
  end

  // Divide by voice_count + 1, truncating toward zero on the magnitude
  logic [M3_W-1:0] m3;
  logic [SW-1:0]   quot;
  logic [SW-1:0]   q;
  logic            q_neg;

  assign m3 = M3_W'(mag) * M3_W'(wuo_pkg::DIV3_MUL);

  always_comb begin
    case (voice_count)
      2'd1:    quot = SW'(mag >> 1);
      2'd2:    quot = m3[wuo_pkg::DIV3_SHIFT +: SW];
      2'd3:    quot = SW'(mag >> 2);
      default: quot = SW'(mag);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      q     <= quot;
      q_neg <= neg;
    end
  end

  // Mix accumulator
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] term;
  assign term = q_neg ? -$signed(ACC_W'(q)) : $signed(ACC_W'(q));

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sum <= '0;
    end else if (cmd.accum) begin
      sum <= sum + term;
    end
  end

  // Double and saturate into the output register
  logic signed [ACC_W:0]  dbl;
  logic signed [SW-1:0]   sat;
  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((1 << (SW - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = -(ACC_W + 1)'(1 << (SW - 1));

  assign dbl = $signed({sum, 1'b0});
  always_comb begin
    if (dbl > SAT_HI) begin
      sat = SAT_HI[SW-1:0];
    end else if (dbl < SAT_LO) begin
      sat = SAT_LO[SW-1:0];
    end else begin
      sat = dbl[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample <= sat;
    end
  end

  // Status back to the sequencer
  assign status = '{active: active_vc, out_blocked: out_valid && out_stall};

endmodule

[rtl/wuo_controller.sv]
// Sequencer: steps each active voice through phase update, two table reads and the mix.
module wuo_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                opcode,
  output logic                in_stall,
  output wuo_pkg::dp_cmd_t    cmd,
  input  wuo_pkg::dp_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PHASE,
    S_READ_A,
    S_READ_B,
    S_MUL,
    S_INTERP,
    S_DIV,
    S_ACC,
    S_DONE
  } state_t;

  state_t                      state;
  logic [wuo_pkg::VOICE_W-1:0] voice;
  logic [wuo_pkg::VOICE_W:0]   voice_inc;

  assign voice_inc = {1'b0, voice} + (wuo_pkg::VOICE_W + 1)'(1);
  assign in_stall  = (state != S_IDLE);

  // State and voice counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      voice <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && opcode == wuo_pkg::OP_TICK) begin
            voice <= '0;
            state <= (status.active == '0) ? S_DONE : S_PHASE;
          end
        end
        S_PHASE:  state <= S_READ_A;
        S_READ_A: state <= S_READ_B;
        S_READ_B: state <= S_MUL;
        S_MUL:    state <= S_INTERP;
        S_INTERP: state <= S_DIV;
        S_DIV:    state <= S_ACC;
        S_ACC: begin
          if (voice_inc == {1'b0, status.active}) begin
            state <= S_DONE;
          end else begin
            voice <= voice_inc[wuo_pkg::VOICE_W-1:0];
            state <= S_PHASE;
          end
        end
        S_DONE: begin
          if (!status.out_blocked) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath commands
  always_comb begin
    cmd       = '0;
    cmd.voice = voice;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.table_write = (opcode == wuo_pkg::OP_LOAD);
          cmd.clear       = (opcode == wuo_pkg::OP_TICK);
        end
      end
      S_PHASE:  cmd.phase_step = 1'b1;
      S_READ_A: cmd.read_a     = 1'b1;
      S_READ_B: cmd.read_b     = 1'b1;
      S_MUL:    cmd.mul        = 1'b1;
      S_INTERP: cmd.interp     = 1'b1;
      S_DIV:    cmd.scale      = 1'b1;
      S_ACC:    cmd.accum      = 1'b1;
      S_DONE:   cmd.emit       = !status.out_blocked;
      default: ;
    endcase
  end

endmodule

[rtl/wavetable_unison_oscillator_core.sv]
// Load item: the next item is taken in the following cycle.
// Tick item: the input stalls until the sample is emitted; each active voice in turn goes
// through phase step, two reads, multiply, interpolate, scale, add, as the single table
// read port allows.
// Reset clears config registers to defaults and all voice phases to zero;
// the wavetable is not cleared and holds garbage until written.
module wavetable_unison_oscillator_core #(
  parameter int TABLE_DEPTH = 2048,
  parameter int MAX_VOICES  = 3,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [wuo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wuo_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [wuo_pkg::TADDR_W-1:0]         table_address,
  input  logic signed [wuo_pkg::SAMPLE_W-1:0] table_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wuo_pkg::SAMPLE_W-1:0] sample
);

  wuo_pkg::dp_cmd_t    cmd;
  wuo_pkg::dp_status_t status;

  wuo_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  wuo_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_VOICES  (MAX_VOICES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .table_address    (table_address),
    .table_value      (table_value),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sample           (sample)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the unison wavetable oscillator core.
module testbench;

  localparam int          SETTLE      = 32;         // covers the longest tick, with three voices
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          DEPTH       = 2048;
  localparam int          VOICES      = 3;
  localparam logic [26:0] STEP_MAX    = '1;

  typedef enum logic [1:0] {ROW_REG, ROW_LOAD, ROW_TICK} row_kind_t;

  // One directed step: a register write, a table load or a tick
  typedef struct packed {
    row_kind_t           kind;
    wuo_pkg::reg_index_t target;
    logic [26:0]         arg;
    logic signed [15:0]  value;
    logic                typed;
    logic signed [15:0]  want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [25] = '{
    '{ROW_REG,  wuo_pkg::REG_PHASE_INC,    27'd0,       16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_DETUNE_INC,   27'd0,       16'sd0,     1'b0, 16'sd0},
    '{ROW_LOAD, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sh7FFF,  1'b0, 16'sd0},
    '{ROW_LOAD, wuo_pkg::REG_TABLE_LENGTH, 27'd1,       16'sh8000,  1'b0, 16'sd0},
    // one voice parked on entry 0, halved then doubled
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b1, 16'sd32766},
    '{ROW_REG,  wuo_pkg::REG_VOICE_COUNT,  27'd0,       16'sd0,     1'b0, 16'sd0},
    // no active voice
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b1, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_VOICE_COUNT,  27'd3,       16'sd0,     1'b0, 16'sd0},
    // three voices at full scale saturate high
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b1, 16'sh7FFF},
    '{ROW_LOAD, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sh8000,  1'b0, 16'sd0},
    // and low
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b1, 16'sh8000},
    '{ROW_LOAD, wuo_pkg::REG_TABLE_LENGTH, 27'd2047,    16'sd12345, 1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_TABLE_LENGTH, 27'd2,       16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_PHASE_INC,    27'h10000,   16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_VOICE_COUNT,  27'd2,       16'sd0,     1'b0, 16'sd0},
    // last entry interpolates toward entry 0
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0},
    // phase lands exactly on the length and wraps to zero
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_DETUNE_INC,   27'h7FFFFFF, 16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0},
    // length below two, phase still past the end after the wrap
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_TABLE_LENGTH, 27'd4095,    16'sd0,     1'b0, 16'sd0},
    '{ROW_REG,  wuo_pkg::REG_PHASE_INC,    27'h7FFFFFF, 16'sd0,     1'b0, 16'sd0},
    // length above depth, phase overflows 27 bits
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0},
    '{ROW_LOAD, wuo_pkg::REG_TABLE_LENGTH, 27'd1000,    16'shFFFF,  1'b0, 16'sd0},
    '{ROW_TICK, wuo_pkg::REG_TABLE_LENGTH, 27'd0,       16'sd0,     1'b0, 16'sd0}
  };

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_write_enable;
  logic [wuo_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [wuo_pkg::CFG_DATA_W-1:0]      cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic                                opcode;
  logic [wuo_pkg::TADDR_W-1:0]         table_address;
  logic signed [wuo_pkg::SAMPLE_W-1:0] table_value;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [wuo_pkg::SAMPLE_W-1:0] sample;

  // Shadow registers and state of the oscillator
  logic [wuo_pkg::LEN_W-1:0]   len_reg = wuo_pkg::LEN_RESET;
  logic [wuo_pkg::PHASE_W-1:0] pinc_reg = wuo_pkg::PINC_RESET;
  logic [wuo_pkg::PHASE_W-1:0] det_reg = wuo_pkg::DET_RESET;
  logic [wuo_pkg::VC_W-1:0]    vc_reg = wuo_pkg::VC_RESET;
  logic [wuo_pkg::PHASE_W-1:0] phase_acc [VOICES] = '{default: '0};
  logic signed [15:0]          wave_mem [DEPTH];
  bit                          wave_written [DEPTH];

  logic signed [15:0]          pending_samples [$];
  logic signed [15:0]          front_sample;
  int                          mismatch_count = 0;
  int                          samples_seen = 0;
  int                          cycle_count = 0;
  int                          hold_left = 0;
  int                          pause_left = 0;
  bit                          held_once = 1'b0;

  wavetable_unison_oscillator_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .table_address    (table_address),
    .table_value      (table_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sample           (sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long; none in calm windows
  function automatic int idle_cycles();
    int r;
    if (cycle_count % 1000 < 150) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int eff_len();
    int l;
    l = len_reg;
    if (l < 2) l = 2;
    if (l > DEPTH) l = DEPTH;
    return l;
  endfunction

  function automatic int active_voices();
    return (vc_reg > VOICES) ? VOICES : vc_reg;
  endfunction

  // Phase of voice j after one tick, wrapped once and kept to 27 bits
  function automatic logic [wuo_pkg::PHASE_W-1:0] advanced_phase(int j);
    longint inc, p, lenfix;
    inc = longint'(pinc_reg) + longint'(j) * longint'(det_reg);
    p = longint'(phase_acc[j]) + inc;
    lenfix = longint'(eff_len()) << 16;
    if (p >= lenfix) p -= lenfix;
    return p[wuo_pkg::PHASE_W-1:0];
  endfunction

  // Linear interpolation; reads past the length fall back to entry 0
  function automatic int interpolated_entry(logic [wuo_pkg::PHASE_W-1:0] ph);
    int len, idx, a, b;
    longint frac, prod;
    len = eff_len();
    idx = int'(ph >> 16);
    a = wave_mem[(idx < len) ? idx : 0];
    b = wave_mem[(idx + 1 < len) ? idx + 1 : 0];
    frac = ph[15:0];
    prod = longint'(b - a) * frac;
    return a + int'(prod >>> 16);
  endfunction

  // Step all active voices and mix them into one sample
  task automatic mix_next_sample(output logic signed [15:0] mixed);
    int j, divisor, sum;
    divisor = int'(vc_reg) + 1;
    sum = 0;
    for (j = 0; j < active_voices(); j++) begin
      phase_acc[j] = advanced_phase(j);
      sum += interpolated_entry(phase_acc[j]) / divisor;
    end
    sum *= 2;
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    mixed = sum[15:0];
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until taken, then update the shadow state
  task automatic offer_item(input logic op, input logic [10:0] addr,
                            input logic signed [15:0] val, input logic typed,
                            input logic signed [15:0] want);
    int gap;
    logic signed [15:0] mixed;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    table_address <= addr;
    table_value   <= val;
    do @(posedge clk); while (in_stall);
    if (op == wuo_pkg::OP_LOAD) begin
      wave_mem[addr]     = val;
      wave_written[addr] = 1'b1;
    end else begin
      mix_next_sample(mixed);
      pending_samples.push_back(typed ? want : mixed);
    end
  endtask

  // Load any entry the coming tick would read before it has been written
  task automatic send_tick(input logic typed, input logic signed [15:0] want);
    int j, k, idx, a;
    for (j = 0; j < active_voices(); j++) begin
      idx = int'(advanced_phase(j) >> 16);
      for (k = 0; k < 2; k++) begin
        a = (idx + k < eff_len()) ? idx + k : 0;
        if (!wave_written[a]) begin
          offer_item(wuo_pkg::OP_LOAD, a[10:0], rand_word(), 1'b0, 16'sd0);
        end
      end
    end
    offer_item(wuo_pkg::OP_TICK, 11'($urandom), 16'($urandom), typed, want);
  endtask

  // Register write once the block has drained
  task automatic write_reg(input wuo_pkg::reg_index_t idx, input logic [26:0] data);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= data;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    case (idx)
      wuo_pkg::REG_TABLE_LENGTH: len_reg  = data[wuo_pkg::LEN_W-1:0];
      wuo_pkg::REG_PHASE_INC:    pinc_reg = data;
      wuo_pkg::REG_DETUNE_INC:   det_reg  = data;
      wuo_pkg::REG_VOICE_COUNT:  vc_reg   = data[wuo_pkg::VC_W-1:0];
      default: ;
    endcase
  endtask

  // New random setting of all four registers, extremes included
  task automatic pick_settings();
    logic [26:0] v;
    case ($urandom_range(0, 7))
      0:       v = 27'($urandom_range(0, 2));
      1:       v = 27'd2048;
      2:       v = 27'd4095;
      3:       v = 27'($urandom_range(2, 4095));
      default: v = 27'($urandom_range(2, 48));
    endcase
    write_reg(wuo_pkg::REG_TABLE_LENGTH, v);
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = STEP_MAX;
      2:       v = 27'($urandom);
      default: v = 27'($urandom_range(0, eff_len() * 65536));
    endcase
    write_reg(wuo_pkg::REG_PHASE_INC, v);
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = STEP_MAX;
      2:       v = 27'($urandom);
      default: v = 27'($urandom_range(0, 1 << 14));
    endcase
    write_reg(wuo_pkg::REG_DETUNE_INC, v);
    v = ($urandom_range(0, 9) == 0) ? 27'd0 : 27'($urandom_range(1, 3));
    write_reg(wuo_pkg::REG_VOICE_COUNT, v);
  endtask

  // Sample checker and output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          mismatch_count++;
          $display("%0t: sample expected none, actual %0d", $time, sample);
        end else begin
          front_sample = pending_samples.pop_front();
          if (sample !== front_sample) begin
            mismatch_count++;
            $display("%0t: sample expected %0d, actual %0d", $time, front_sample, sample);
          end
        end
        samples_seen++;
      end
      // one long hold so the block backs up into its input
      if (!held_once && samples_seen >= 60) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pause_left > 0) begin
        pause_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) pause_left = idle_cycles();
      end
    end
  end

  // Stimulus
  initial begin
    int row, phase_no, item_no;
    logic [10:0] addr;
    rst              <= 1'b1;
    cfg_write_enable <= 1'b0;
    cfg_index        <= wuo_pkg::REG_TABLE_LENGTH;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    opcode           <= wuo_pkg::OP_LOAD;
    table_address    <= '0;
    table_value      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed steps
    for (row = 0; row < 25; row++) begin
      case (DIRECTED[row].kind)
        ROW_REG:  write_reg(DIRECTED[row].target, DIRECTED[row].arg);
        ROW_LOAD: offer_item(wuo_pkg::OP_LOAD, DIRECTED[row].arg[10:0], DIRECTED[row].value,
                             1'b0, 16'sd0);
        default:  send_tick(DIRECTED[row].typed, DIRECTED[row].want);
      endcase
    end

    // random phases: new setting, then a mix of ticks and loads
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      pick_settings();
      for (item_no = 0; item_no < 35; item_no++) begin
        if ($urandom_range(0, 99) < 70) begin
          send_tick(1'b0, 16'sd0);
        end else begin
          addr = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, eff_len() - 1))
                                             : 11'($urandom);
          offer_item(wuo_pkg::OP_LOAD, addr, rand_word(), 1'b0, 16'sd0);
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wuo_pkg.sv
rtl/wuo_datapath.sv
rtl/wuo_controller.sv
rtl/wavetable_unison_oscillator_core.sv
test/testbench.sv
